/* rtl/core/gkr_pkg.sv */
// gkr_pkg: shared constants, helpers and stage type for the gift-128 keyed round unit
// no dependencies; imported by every module of the block
package gkr_pkg;

    localparam int NIBBLES    = 32;
    localparam int STATE_BITS = 128;
    localparam int HALF_BITS  = 64;

    // 4-bit gift s-box, indexed by the input nibble
    localparam logic [3:0] SBOX [16] = '{
        4'd1, 4'd10, 4'd4, 4'd12, 4'd6, 4'd15, 4'd3, 4'd9,
        4'd2, 4'd13, 4'd11, 4'd7, 4'd5, 4'd0, 4'd8, 4'd14
    };

    // destination of bit k within each group of 16 source bits
    localparam logic [6:0] PERM_BASE [16] = '{
        7'd0,  7'd33, 7'd66, 7'd99, 7'd96, 7'd1,  7'd34, 7'd67,
        7'd64, 7'd97, 7'd2,  7'd35, 7'd32, 7'd65, 7'd98, 7'd3
    };

    // payload between the s-box lanes and the merge stage
    typedef struct packed {
        logic [STATE_BITS-1:0] state;
        logic [STATE_BITS-1:0] key;
    } gkr_stage_t;

    // bit i = 16g + k moves to PERM_BASE[k] + 4g, modulo 128
    function automatic logic [6:0] perm_pos(input logic [6:0] i);
        logic [6:0] group_ofs;
        group_ofs = {i[6:4], 2'b00};
        return PERM_BASE[i[3:0]] + group_ofs;
    endfunction

endpackage

/* rtl/core/gkr_in_if.sv */
// gkr_in_if: valid/ready channel carrying one state and round key item
// depends on nothing
interface gkr_in_if;

    logic        valid;
    logic        ready;
    logic [63:0] state_lo;
    logic [63:0] state_hi;
    logic [63:0] key_lo;
    logic [63:0] key_hi;

    modport source (output valid, output state_lo, output state_hi,
                    output key_lo, output key_hi, input ready);
    modport sink   (input valid, input state_lo, input state_hi,
                    input key_lo, input key_hi, output ready);

endinterface

/* rtl/core/gkr_out_if.sv */
// gkr_out_if: valid/ready channel carrying one round result item
// depends on nothing
interface gkr_out_if;

    logic        valid;
    logic        ready;
    logic [63:0] next_lo;
    logic [63:0] next_hi;

    modport source (output valid, output next_lo, output next_hi, input ready);
    modport sink   (input valid, input next_lo, input next_hi, output ready);

endinterface

/* rtl/core/gkr_sbox_lane.sv */
// gkr_sbox_lane: one s-box lane, substitutes a single nibble
// depends on gkr_pkg for the s-box table
module gkr_sbox_lane (
    input  logic [3:0] nibble,
    output logic [3:0] sub
);
    import gkr_pkg::*;

    // table lookup
    assign sub = SBOX[nibble];

endmodule

/* rtl/core/gkr_merge.sv */
// gkr_merge: merges the lane outputs through the bit permutation and adds the round key
// depends on gkr_pkg for the permutation and the stage type
module gkr_merge (
    input  gkr_pkg::gkr_stage_t      stage,
    output logic [127:0]             round_out
);
    import gkr_pkg::*;

    logic [STATE_BITS-1:0] permuted;

    // fixed wiring: every source bit lands at its permuted position
    always_comb
    begin
        permuted = '0;
        for (int i = 0; i < STATE_BITS; i++)
        begin
            permuted[perm_pos(7'(i))] = stage.state[i];
        end
    end

    // round key addition
    assign round_out = permuted ^ stage.key;

endmodule

/* rtl/core/gift128_keyed_round_unit.sv */
// gift128_keyed_round_unit: top level of the gift-128 keyed round unit
// depends on gkr_pkg, gkr_in_if, gkr_out_if, gkr_sbox_lane and gkr_merge
//
// Usage:
//   request carries a 128-bit state and a 128-bit round key as 64-bit halves;
//   an item is taken at a rising edge with valid and ready both high.
//   result carries next_lo/next_hi, the state after s-box layer, bit
//   permutation and key xor, one result item per request item, in order.
//   An accepted item passes the lane stage register, then the output register,
//   before it shows on result.
//   Throughput: one item per cycle while result does not stall, set by the
//   two-stage pipeline of 32 parallel s-box lanes followed by the registered merge stage.
//   When result stalls, the lane stage can still take one more item if it is
//   empty; after that request.ready drops until the output register drains.
//   Nothing is lost or repeated under stalls.
//   Reset (rst_n low, asynchronous) empties both stages; no item is pending
//   afterwards and request.ready is high.
module gift128_keyed_round_unit (
    input  logic             clk,
    input  logic             rst_n,
    gkr_in_if.sink           request,
    gkr_out_if.source        result
);
    import gkr_pkg::*;

    logic [STATE_BITS-1:0] state_in;
    logic [STATE_BITS-1:0] lanes_out;
    logic [STATE_BITS-1:0] round_out;

    gkr_stage_t            s1_data_reg;
    logic                  s1_valid_reg;
    logic                  s1_ready;
    logic [STATE_BITS-1:0] out_data_reg;
    logic                  out_valid_reg;
    logic                  out_ready;

    assign state_in = {request.state_hi, request.state_lo};

    // parallel s-box lanes, one per nibble
    for (genvar n = 0; n < NIBBLES; n++)
    begin : g_lane
        gkr_sbox_lane u_lane (
            .nibble (state_in[4*n +: 4]),
            .sub    (lanes_out[4*n +: 4])
        );
    end

    // stage handshake: a stage loads when empty or when it drains this cycle
    assign out_ready     = !out_valid_reg || result.ready;
    assign s1_ready      = !s1_valid_reg || out_ready;
    assign request.ready = s1_ready;

    // lane stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && request.valid)
        begin
            s1_data_reg.state <= lanes_out;
            s1_data_reg.key   <= {request.key_hi, request.key_lo};
        end
    end

    // permutation and key addition
    gkr_merge u_merge (
        .stage     (s1_data_reg),
        .round_out (round_out)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            out_data_reg <= round_out;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.next_lo = out_data_reg[HALF_BITS-1:0];
    assign result.next_hi = out_data_reg[STATE_BITS-1:HALF_BITS];

endmodule

/* tb/gift128_keyed_round_unit_test.sv */
// gift128_keyed_round_unit_test: self-checking bench for the gift-128 keyed round unit
// depends on gkr_in_if, gkr_out_if and gift128_keyed_round_unit; predicts each round
// result and checks it in order against the result channel under random stalls
module gift128_keyed_round_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;

    // 4-bit s-box and per-group bit destinations of the round
    localparam logic [3:0] NIBBLE_SUB [16] = '{
        4'd1, 4'd10, 4'd4, 4'd12, 4'd6, 4'd15, 4'd3, 4'd9,
        4'd2, 4'd13, 4'd11, 4'd7, 4'd5, 4'd0, 4'd8, 4'd14
    };
    localparam int PERM_GROUP_BASE [16] = '{
        0, 33, 66, 99, 96, 1, 34, 67, 64, 97, 2, 35, 32, 65, 98, 3
    };

    logic clk = 1'b0;
    logic rst_n;
    logic idle_enable = 1'b1;
    int error_count = 0;
    logic [127:0] expected_next_q [$];

    gkr_in_if  req_if ();
    gkr_out_if res_if ();

    gift128_keyed_round_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .result  (res_if)
    );

    // clock
    always #5 clk = ~clk;

    // s-box layer, bit permutation, then key xor
    function automatic logic [127:0] gift_round(input logic [127:0] st,
                                                input logic [127:0] key);
        logic [127:0] subbed;
        logic [127:0] moved;
        int i;
        int dst;
        for (i = 0; i < 32; i++)
            subbed[4*i +: 4] = NIBBLE_SUB[st[4*i +: 4]];
        moved = '0;
        for (i = 0; i < 128; i++)
        begin
            dst = (PERM_GROUP_BASE[i % 16] + 4 * (i / 16)) % 128;
            moved[dst] = subbed[i];
        end
        return moved ^ key;
    endfunction

    // random 128-bit word: mostly uniform, sometimes sparse, dense or one repeated nibble
    function automatic logic [127:0] pick_word();
        logic [127:0] w;
        logic [3:0] nib;
        w = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 7))
            0:
            begin
                w = '0;
                repeat ($urandom_range(1, 4)) w[$urandom_range(0, 127)] = 1'b1;
            end
            1:
            begin
                w = '1;
                repeat ($urandom_range(1, 4)) w[$urandom_range(0, 127)] = 1'b0;
            end
            2:
            begin
                nib = 4'($urandom_range(0, 15));
                w = {32{nib}};
            end
            default: ;
        endcase
        return w;
    endfunction

    // drive one state/key item and wait until it is taken
    task automatic send_round_item(input logic [127:0] st, input logic [127:0] key);
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 17);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.state_lo <= st[63:0];
        req_if.state_hi <= st[127:64];
        req_if.key_lo   <= key[63:0];
        req_if.key_hi   <= key[127:64];
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        expected_next_q.push_back(gift_round(st, key));
    endtask

    // stop sending and wait until every predicted round has come out
    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        while (expected_next_q.size() != 0) @(posedge clk);
    endtask

    // every s-box input in every nibble, single bits at the half edges, plain keys
    task automatic test_directed_patterns();
        logic [3:0] nib;
        logic [127:0] st;
        int n;
        for (n = 0; n < 16; n++)
        begin
            nib = 4'(n);
            send_round_item({32{nib}}, '0);
        end
        st = '0; st[0]   = 1'b1; send_round_item(st, '0);
        st = '0; st[63]  = 1'b1; send_round_item(st, '1);
        st = '0; st[64]  = 1'b1; send_round_item(st, '0);
        st = '0; st[127] = 1'b1; send_round_item(st, '1);
        send_round_item('0, '1);
        send_round_item({32{4'h5}}, {32{4'hA}});
        send_round_item({32{4'hA}}, {32{4'h5}});
    endtask

    // random states and keys with idling switched on and off in stretches
    task automatic test_random_traffic(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
                idle_enable = ($urandom_range(0, 3) != 0);
            send_round_item(pick_word(), pick_word());
        end
        idle_enable = 1'b1;
    endtask

    // short bursts, each followed by a full drain and a random hold-off
    task automatic test_drain_pause(input int rounds);
        int r;
        int n;
        for (r = 0; r < rounds; r++)
        begin
            for (n = $urandom_range(1, 40); n > 0; n--)
                send_round_item(pick_word(), pick_word());
            wait_for_drain();
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    // back-to-back items with both sides always willing
    task automatic test_streaming(input int count);
        int n;
        idle_enable = 1'b0;
        for (n = 0; n < count; n++)
            send_round_item(pick_word(), pick_word());
    endtask

    // result sink with random stall bursts
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && idle_enable && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 17);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_next_q.size() == 0)
            begin
                $error("unexpected result item: next_hi %h next_lo %h",
                       res_if.next_hi, res_if.next_lo);
                error_count++;
            end
            else
            begin
                want = expected_next_q.pop_front();
                if (res_if.next_lo !== want[63:0])
                begin
                    $error("next_lo mismatch: expected %h actual %h",
                           want[63:0], res_if.next_lo);
                    error_count++;
                end
                if (res_if.next_hi !== want[127:64])
                begin
                    $error("next_hi mismatch: expected %h actual %h",
                           want[127:64], res_if.next_hi);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles where neither channel moves an item
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("gift128_keyed_round_unit verification failed");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n           <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.state_lo <= '0;
        req_if.state_hi <= '0;
        req_if.key_lo   <= '0;
        req_if.key_hi   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_patterns();
        test_random_traffic(1100);
        test_drain_pause(6);
        test_streaming(300);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_next_q.size() == 0)
            $display("gift128_keyed_round_unit verification clean");
        else
            $display("gift128_keyed_round_unit verification failed");
        $finish;
    end

endmodule
